FILE: hw/rtl/ttb_pkg.sv
// ttb_pkg: shared constants and types for the triangle tangent/binormal block.
// No dependencies.
`default_nettype none
package ttb_pkg;
  localparam int INDEX_WIDTH = 16;
  localparam int POS_W = 32;
  localparam int TEX_W = 24;
  localparam int DT_W  = 25;   // texture delta
  localparam int DP_W  = 33;   // position edge
  localparam int VEC_W = 60;   // raw tangent/binormal component
  localparam int MAG_W = 59;
  localparam int SQ_W  = 62;   // sum of squares of normalised components
  localparam int LEN_W = 31;
  localparam int NUM_W = 46;   // m << 15

  typedef logic signed [15:0] q15_t;
endpackage
`default_nettype wire

FILE: hw/rtl/triangle_tangent_binormal.sv
// triangle_tangent_binormal: top level, sequencer plus one shared multiplier,
// shift stage, square-root and divide steps. Depends on ttb_pkg.
//
// Usage
//   Input channel (in_valid/in_stall): one vertex per transfer. The first two
//   vertices of a triangle are stored as they are accepted. The third starts the
//   computation; in_stall stays high until its three results have gone.
//   Output channel (out_valid/out_stall): three transfers per triangle, for
//   the third, second and first vertex; last_of_face marks the first vertex.
//   Sequence for the third vertex: the multiply steps (determinant and raw
//   vector products), then per vector a magnitude step, scaling, squares,
//   bit-serial square-root steps and a restoring divide per component,
//   before out_valid rises; a zero determinant goes from the multiply steps
//   straight to the output state.
//   A stalled result holds its payload; the block then waits in its output
//   state and accepts nothing.
//   Reset (rst, synchronous) clears the slot count and held vertices and
//   drops out_valid.
//   Degenerate triangles (zero determinant or zero-length vector) give zero
//   vectors with degenerate set.
`default_nettype none
module triangle_tangent_binormal (
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_stall,
  input  wire  [ttb_pkg::INDEX_WIDTH-1:0] vertex_index,
  input  wire  signed [31:0] position_x,
  input  wire  signed [31:0] position_y,
  input  wire  signed [31:0] position_z,
  input  wire  signed [23:0] tex_u,
  input  wire  signed [23:0] tex_v,
  output logic out_valid,
  input  wire  out_stall,
  output logic [ttb_pkg::INDEX_WIDTH-1:0] target_vertex,
  output logic signed [15:0] tangent_x,
  output logic signed [15:0] tangent_y,
  output logic signed [15:0] tangent_z,
  output logic signed [15:0] binormal_x,
  output logic signed [15:0] binormal_y,
  output logic signed [15:0] binormal_z,
  output logic degenerate,
  output logic last_of_face
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;  // det and raw vector products
  localparam logic [3:0] S_MAG   = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_ROOT  = 4'd5;
  localparam logic [3:0] S_DIVI  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam int DT_W = ttb_pkg::DT_W;
  localparam int DP_W = ttb_pkg::DP_W;
  localparam int VEC_W = ttb_pkg::VEC_W;
  localparam int MAG_W = ttb_pkg::MAG_W;
  localparam int SQ_W = ttb_pkg::SQ_W;
  localparam int LEN_W = ttb_pkg::LEN_W;
  localparam int NUM_W = ttb_pkg::NUM_W;

  logic [3:0] state;
  logic [1:0] slot_count;
  logic [ttb_pkg::INDEX_WIDTH-1:0] held_index [2];
  logic signed [31:0] held_position [6];
  logic signed [23:0] held_texture [4];
  logic [ttb_pkg::INDEX_WIDTH-1:0] idx3;

  // deltas
  logic signed [DT_W-1:0] du1, dv1, du2, dv2;
  logic signed [DP_W-1:0] e1 [3];
  logic signed [DP_W-1:0] e2 [3];
  logic signed [VEC_W-1:0] vec [6];  // tangent x,y,z then binormal x,y,z
  logic signed [VEC_W-1:0] prod_a;   // first product of a pair
  logic signed [51:0] det_a;
  logic det_neg, det_zero, degen;
  logic [4:0] step;
  logic vsel;                       // 0 tangent, 1 binormal

  // normalisation registers
  logic [MAG_W-1:0] m [3];
  logic [SQ_W-1:0] sum, rem;
  logic [SQ_W-1:0] rbit;
  logic [SQ_W-1:0] res;
  logic [LEN_W-1:0] len;
  logic [1:0] comp;
  logic [5:0] dcnt;
  logic [NUM_W-1:0] num;
  logic [LEN_W:0] drem;
  logic [NUM_W-1:0] quo;
  logic signed [15:0] outv [6];
  logic [1:0] ocnt;

  // base of the vector under normalisation, and of the held slot being loaded
  logic [2:0] vbase;
  logic [2:0] pbase;
  logic [1:0] tbase;
  assign vbase = vsel ? 3'd3 : 3'd0;
  assign pbase = slot_count[0] ? 3'd3 : 3'd0;
  assign tbase = {slot_count[0], 1'b0};

  // Shared multiplier: one signed 33 x 25 product per cycle.
  logic signed [DP_W-1:0] mul_a;
  logic signed [DT_W-1:0] mul_b;
  logic signed [VEC_W-1:0] mul_p;
  assign mul_p = VEC_W'(mul_a) * VEC_W'(mul_b);

  logic [4:0] sm2;
  logic [2:0] vi3;  // vector component under multiply
  assign sm2 = step - 5'd2;
  assign vi3 = 3'(sm2[4:2]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (step < 5'd2) begin
      mul_a = DP_W'(step[0] ? du2 : du1);
      mul_b = step[0] ? dv1 : dv2;
    end else begin
      // step-2 = 4*comp + k : k0 dv2*e1, k1 dv1*e2 (tangent); k2 du1*e2, k3 du2*e1
      unique case (2'(step - 5'd2))
        2'd0: begin mul_a = e1[2'(vi3)]; mul_b = dv2; end
        2'd1: begin mul_a = e2[2'(vi3)]; mul_b = dv1; end
        2'd2: begin mul_a = e2[2'(vi3)]; mul_b = du1; end
        default: begin mul_a = e1[2'(vi3)]; mul_b = du2; end
      endcase
    end
  end

  // magnitude of selected raw vector
  function automatic logic [MAG_W-1:0] fmag(input logic signed [VEC_W-1:0] x);
    logic [VEC_W-1:0] u;
    u = x[VEC_W-1] ? VEC_W'(-x) : VEC_W'(x);
    return u[MAG_W-1:0];
  endfunction

  logic [MAG_W-1:0] mx;
  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
  end

  logic [SQ_W-1:0] sq;
  assign sq = SQ_W'(m[comp][30:0]) * SQ_W'(m[comp][30:0]);

  logic [SQ_W-1:0] rtry;
  assign rtry = res + rbit;

  logic [LEN_W:0] dsh;
  assign dsh = {drem[LEN_W-1:0], num[NUM_W-1]};

  logic signed [VEC_W-1:0] sel_c;
  assign sel_c = vec[vbase + 3'(comp)];

  logic [NUM_W-1:0] qsat;
  logic neg;
  logic signed [16:0] sv;
  always_comb begin
    qsat = (quo > NUM_W'(32768)) ? NUM_W'(32768) : quo;
    neg = sel_c[VEC_W-1] != det_neg;
    sv = neg ? -17'(qsat) : 17'(qsat);
    if (sv > 17'sd32767) sv = 17'sd32767;
  end

  assign in_stall = (state != S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      slot_count <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 2; i++) held_index[i] <= '0;
      for (int i = 0; i < 6; i++) held_position[i] <= '0;
      for (int i = 0; i < 4; i++) held_texture[i] <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (slot_count < 2'd2) begin
              held_index[slot_count[0]] <= vertex_index;
              held_position[pbase] <= position_x;
              held_position[pbase + 3'd1] <= position_y;
              held_position[pbase + 3'd2] <= position_z;
              held_texture[tbase] <= tex_u;
              held_texture[tbase + 2'd1] <= tex_v;
              slot_count <= slot_count + 2'd1;
            end else begin
              slot_count <= '0;
              idx3 <= vertex_index;
              e1[0] <= DP_W'(held_position[3]) - DP_W'(held_position[0]);
              e1[1] <= DP_W'(held_position[4]) - DP_W'(held_position[1]);
              e1[2] <= DP_W'(held_position[5]) - DP_W'(held_position[2]);
              e2[0] <= DP_W'(position_x) - DP_W'(held_position[0]);
              e2[1] <= DP_W'(position_y) - DP_W'(held_position[1]);
              e2[2] <= DP_W'(position_z) - DP_W'(held_position[2]);
              du1 <= DT_W'(held_texture[2]) - DT_W'(held_texture[0]);
              dv1 <= DT_W'(held_texture[3]) - DT_W'(held_texture[1]);
              du2 <= DT_W'(tex_u) - DT_W'(held_texture[0]);
              dv2 <= DT_W'(tex_v) - DT_W'(held_texture[1]);
              step <= '0;
              degen <= 1'b0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (step == 5'd0) det_a <= 52'(mul_p);
          else if (step == 5'd1) begin
            det_zero <= (det_a == 52'(mul_p));
            det_neg <= det_a < 52'(mul_p);
          end else if (!sm2[0]) prod_a <= mul_p;
          else vec[(sm2[1] ? 3'd3 : 3'd0) + vi3] <= prod_a - mul_p;
          if (step == 5'd13) begin
            vsel <= 1'b0;
            state <= det_zero ? S_OUT : S_MAG;
            if (det_zero) begin
              degen <= 1'b1;
              for (int i = 0; i < 6; i++) outv[i] <= '0;
              ocnt <= '0;
              out_valid <= 1'b1;
            end
          end
          step <= step + 5'd1;
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) m[i] <= fmag(vec[vbase + 3'(i)]);
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // one bit of scaling per cycle towards [2^29, 2^30)
          if (mx == '0) begin
            degen <= 1'b1;
            for (int i = 0; i < 6; i++) outv[i] <= '0;
            ocnt <= '0;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (mx >= MAG_W'(64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (mx < MAG_W'(64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            comp <= '0;
            sum <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sum <= sum + sq;
          if (comp == 2'd2) begin
            rem <= sum + sq;
            res <= '0;
            rbit <= SQ_W'(64'd1 << 60);
            state <= S_ROOT;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_ROOT: begin
          if (rem >= rtry) begin
            rem <= rem - rtry;
            res <= (res >> 1) + rbit;
          end else begin
            res <= res >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit == SQ_W'(1)) begin
            comp <= '0;
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          len <= res[LEN_W-1:0];
          num <= (NUM_W'(m[comp]) << 15) + NUM_W'(res[LEN_W-1:1]);
          drem <= '0;
          quo <= '0;
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle; quo is complete once
          // dcnt reaches NUM_W and that cycle's extra step is discarded
          if (dsh >= {1'b0, len}) begin
            drem <= dsh - {1'b0, len};
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            drem <= dsh;
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
          num <= num << 1;
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(NUM_W)) begin
            outv[vbase + 3'(comp)] <= sv[15:0];
            if (comp == 2'd2) begin
              if (vsel) begin
                ocnt <= '0;
                out_valid <= 1'b1;
                state <= S_OUT;
              end else begin
                vsel <= 1'b1;
                state <= S_MAG;
              end
            end else begin
              comp <= comp + 2'd1;
              state <= S_DIVI;
            end
            dcnt <= '0;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            ocnt <= ocnt + 2'd1;
            if (ocnt == 2'd2) begin
              out_valid <= 1'b0;
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_comb begin
    unique case (ocnt)
      2'd0: target_vertex = idx3;
      2'd1: target_vertex = held_index[1];
      default: target_vertex = held_index[0];
    endcase
  end
  assign tangent_x = outv[0];
  assign tangent_y = outv[1];
  assign tangent_z = outv[2];
  assign binormal_x = outv[3];
  assign binormal_y = outv[4];
  assign binormal_z = outv[5];
  assign degenerate = degen;
  assign last_of_face = (ocnt == 2'd2);

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("out_valid outside output state");
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while results pending");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_face) |=> !out_valid)
    else $error("results continue after last of face");
endmodule
`default_nettype wire

FILE: dv/ttb_checker.sv
// ttb_checker: watches both channels of triangle_tangent_binormal, predicts the
// per-vertex tangent and binormal, and compares. Depends on ttb_pkg.
module ttb_checker (
  input  wire clk,
  input  wire rst,
  input  wire in_valid,
  input  wire in_stall,
  input  wire [ttb_pkg::INDEX_WIDTH-1:0] vertex_index,
  input  wire signed [31:0] position_x,
  input  wire signed [31:0] position_y,
  input  wire signed [31:0] position_z,
  input  wire signed [23:0] tex_u,
  input  wire signed [23:0] tex_v,
  input  wire out_valid,
  input  wire out_stall,
  input  wire [ttb_pkg::INDEX_WIDTH-1:0] target_vertex,
  input  wire signed [15:0] tangent_x,
  input  wire signed [15:0] tangent_y,
  input  wire signed [15:0] tangent_z,
  input  wire signed [15:0] binormal_x,
  input  wire signed [15:0] binormal_y,
  input  wire signed [15:0] binormal_z,
  input  wire degenerate,
  input  wire last_of_face,
  output int  fail_count,
  output int  pending_count,
  output int  result_count,
  output int  degen_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttb_pkg::*;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] vtx;
    q15_t tx, ty, tz, bx, by, bz;
    logic degen, last;
  } vertex_result_t;

  vertex_result_t vertex_results_due[$];

  // held vertices of the open triangle
  int unsigned      held_count;
  logic signed [63:0] held_pos [2][3];
  logic signed [63:0] held_tex [2][2];
  logic [INDEX_WIDTH-1:0] held_vtx [2];

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // scale to [2^29,2^30), divide by floor length, round half away, saturate
  function automatic bit unit_q15(input logic signed [63:0] c [3], input bit flip,
                                  output q15_t o [3]);
    logic [63:0] m [3];
    logic [63:0] mx, sum, len, q;
    logic signed [63:0] v;
    bit neg;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    if (len == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 15) + (len >> 1)) / len;
      neg = (c[i] < 0) != flip;
      if (q > 32768) q = 32768;
      v = neg ? -$signed(q) : $signed(q);
      if (v > 32767) v = 32767;
      o[i] = v[15:0];
    end
    return 1;
  endfunction

  task automatic take_vertex();
    logic signed [63:0] p3 [3], e1 [3], e2 [3], tv [3], bv [3];
    logic signed [63:0] du1, dv1, du2, dv2, det;
    q15_t t [3], b [3];
    vertex_result_t r;
    bit degen;
    p3[0] = position_x; p3[1] = position_y; p3[2] = position_z;
    if (held_count < 2) begin
      for (int i = 0; i < 3; i++) held_pos[held_count][i] = p3[i];
      held_tex[held_count][0] = tex_u;
      held_tex[held_count][1] = tex_v;
      held_vtx[held_count] = vertex_index;
      held_count++;
      return;
    end
    held_count = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = held_pos[1][i] - held_pos[0][i];
      e2[i] = p3[i] - held_pos[0][i];
      t[i] = 0; b[i] = 0;
    end
    du1 = held_tex[1][0] - held_tex[0][0];
    dv1 = held_tex[1][1] - held_tex[0][1];
    du2 = 64'(tex_u) - held_tex[0][0];
    dv2 = 64'(tex_v) - held_tex[0][1];
    det = du1 * dv2 - du2 * dv1;
    degen = (det == 0);
    if (!degen) begin
      for (int i = 0; i < 3; i++) begin
        tv[i] = dv2 * e1[i] - dv1 * e2[i];
        bv[i] = du1 * e2[i] - du2 * e1[i];
      end
      if (!unit_q15(tv, det < 0, t) || !unit_q15(bv, det < 0, b)) begin
        degen = 1;
        for (int i = 0; i < 3; i++) begin
          t[i] = 0; b[i] = 0;
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      r.vtx = (k == 0) ? vertex_index : held_vtx[2 - k];
      r.tx = t[0]; r.ty = t[1]; r.tz = t[2];
      r.bx = b[0]; r.by = b[1]; r.bz = b[2];
      r.degen = degen;
      r.last = (k == 2);
      vertex_results_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    vertex_result_t got, want;
    if (rst) begin
      held_count <= 0;
    end else begin
      if (in_valid && !in_stall) take_vertex();
      if (out_valid && !out_stall) begin
        got = '{target_vertex, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                binormal_z, degenerate, last_of_face};
        result_count++;
        if (degenerate) degen_count++;
        if (vertex_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%t unexpected result %p", $realtime, got);
        end else begin
          want = vertex_results_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("%t mismatch: expected %p got %p",
                                           $realtime, want, got);
          end
        end
      end
    end
    pending_count = vertex_results_due.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
    result_count = 0;
    degen_count = 0;
    held_count = 0;
  end
endmodule

FILE: dv/tb_triangle_tangent_binormal.sv
// tb_triangle_tangent_binormal: stimulus and verdict for triangle_tangent_binormal.
// Depends on ttb_pkg, the block and ttb_checker.
module tb_triangle_tangent_binormal;
  timeunit 1ns;
  timeprecision 1ps;
  import ttb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [INDEX_WIDTH-1:0] vertex_index = 0;
  logic signed [31:0] position_x = 0, position_y = 0, position_z = 0;
  logic signed [23:0] tex_u = 0, tex_v = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [INDEX_WIDTH-1:0] target_vertex;
  logic signed [15:0] tangent_x, tangent_y, tangent_z;
  logic signed [15:0] binormal_x, binormal_y, binormal_z;
  logic degenerate, last_of_face;

  int fail_count, pending_count, result_count, degen_count;
  int vertices_sent;
  bit quiet_phase = 0;   // no idling on either side
  bit hold_off = 0;      // long receiver hold-off under way

  always #5 clk = ~clk;

  triangle_tangent_binormal dut (.*);
  ttb_checker chk (.*);

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (2000) @(negedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall <= 0;
      end
    end
  end

  // one vertex transfer; payload held while stalled
  task automatic send_vertex(input logic [INDEX_WIDTH-1:0] vi, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [23:0] u, input logic [23:0] v);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1;
    vertex_index <= vi;
    position_x <= px; position_y <= py; position_z <= pz;
    tex_u <= u; tex_v <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    vertices_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 0;
  endtask

  // random but mostly modest geometry: varied scales so shifts go both ways
  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
      default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [23:0] rand_tex();
    case ($urandom_range(0, 2))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 40)) - 20);
      default: return 24'($urandom_range(0, 24'h1ffff));
    endcase
  endfunction

  task automatic wait_drained();
    drop_valid();
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] a;
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: ordinary triangle
    send_vertex(16'h0001, 0, 0, 0, 0, 0);
    send_vertex(16'h0002, 32'h00010000, 0, 0, 24'h010000, 0);
    send_vertex(16'hffff, 0, 32'h00010000, 0, 0, 24'h010000);
    // negative determinant (u flipped)
    send_vertex(16'h0000, 0, 0, 0, 0, 0);
    send_vertex(16'h8000, 32'h00010000, 0, 0, 24'hff0000, 0);
    send_vertex(16'h7fff, 0, 0, 32'h00010000, 0, 24'h010000);
    // zero determinant: collinear texture coordinates
    send_vertex(16'h0010, 1, 2, 3, 24'h000100, 24'h000100);
    send_vertex(16'h0011, 5, 6, 7, 24'h000200, 24'h000200);
    send_vertex(16'h0012, 9, 1, 4, 24'h000300, 24'h000300);
    // zero-length vector: all positions equal
    send_vertex(16'h0020, 32'h12345678, 32'h12345678, 32'h12345678, 0, 0);
    send_vertex(16'h0021, 32'h12345678, 32'h12345678, 32'h12345678, 24'h010000, 0);
    send_vertex(16'h0022, 32'h12345678, 32'h12345678, 32'h12345678, 0, 24'h010000);
    // field extremes
    send_vertex(16'haaaa, 32'h80000000, 32'h7fffffff, 32'h80000000, 24'h800000, 24'h7fffff);
    send_vertex(16'h5555, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 24'h7fffff, 24'h800000);
    send_vertex(16'hffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 24'h800000, 24'h800000);
    // tiny vectors, saturation toward +1.0 on one axis
    send_vertex(16'h0100, 0, 0, 0, 0, 0);
    send_vertex(16'h0101, 1, 0, 0, 1, 0);
    send_vertex(16'h0102, 0, 1, 0, 0, 1);
    wait_drained();

    // long receiver hold-off while vertices keep coming
    hold_off = 1;
    for (int i = 0; i < 12; i++)
      send_vertex(16'($urandom), rand_pos(), rand_pos(), rand_pos(), rand_tex(), rand_tex());
    wait_drained();

    // random triangles
    for (int i = 0; i < 225; i++) begin
      if (i == 180) quiet_phase = 1;
      if (i % 3 == 0 && $urandom_range(0, 9) == 0) begin
        // first vertex on the diagonal with small texture coordinates
        a = rand_pos();
        send_vertex(16'($urandom), a, a, a, 24'h000010, 24'h000020);
      end else begin
        send_vertex(16'($urandom), rand_pos(), rand_pos(), rand_pos(), rand_tex(), rand_tex());
      end
    end
    wait_drained();
    repeat (600) @(negedge clk);

    $display("Sent %0d vertices, checked %0d results (%0d degenerate).",
             vertices_sent, result_count, degen_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // generous stop: 85 triangles plus stalls and hold-off
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
